### rtl/path_operator_tokenizer_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the path operator tokenizer
// Shared concurrent assertion forms, clocked and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef PATH_OPERATOR_TOKENIZER_UNIT_DEFINES_SVH
`define PATH_OPERATOR_TOKENIZER_UNIT_DEFINES_SVH

// same-cycle implication
`define POTOK_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define POTOK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/potok_pkg.sv
// ---------------------------------------------------------------------------
// potok_pkg
// Types, constants and fixed-point helpers of the path operator tokenizer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package potok_pkg;

   localparam int STACK_DEPTH_DEF     = 32;
   localparam int FRACTION_DIGITS_DEF = 5;

   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;
   localparam logic [7:0] CHAR_LOW_A = 8'd97;
   localparam logic [7:0] CHAR_LOW_Z = 8'd122;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_POINT = 8'h2E;
   localparam logic [7:0] CHAR_C     = 8'h63;
   localparam logic [7:0] CHAR_M     = 8'h6D;
   localparam logic [7:0] CHAR_L     = 8'h6C;
   localparam logic [7:0] CHAR_Q     = 8'h71;

   localparam int VALUE_W = 48;
   localparam int NUM_VALUES = 6;

   typedef enum logic [2:0] {
      CMD_MATRIX  = 3'd0,
      CMD_MOVETO  = 3'd1,
      CMD_CURVETO = 3'd2,
      CMD_LINETO  = 3'd3,
      CMD_SAVE    = 3'd4
   } cmd_kind_type;

   // one entry of the front-to-back queue: a push or a command
   typedef struct packed {
      logic         is_cmd;
      cmd_kind_type kind;
      logic [2:0]   pop_n;
      logic         underflow;
      logic [31:0]  int_part;
      logic [19:0]  frac_acc;
      logic [2:0]   frac_cnt;
   } op_type;

   typedef enum logic [1:0] {
      EX_IDLE = 2'd0,
      EX_POP  = 2'd1,
      EX_OUT  = 2'd2
   } exec_state_type;

   function automatic logic [19:0] pow_ten(input logic [2:0] n);
      logic [19:0] r;
      case (n)
         3'd0:    r = 20'd1;
         3'd1:    r = 20'd10;
         3'd2:    r = 20'd100;
         3'd3:    r = 20'd1000;
         3'd4:    r = 20'd10000;
         3'd5:    r = 20'd100000;
         3'd6:    r = 20'd1000000;
         default: r = 20'd1;
      endcase
      return r;
   endfunction

   // floor(2^36 / 10^n); no fraction digits means a zero fraction
   function automatic logic [33:0] recip_ten(input logic [2:0] n);
      logic [33:0] r;
      case (n)
         3'd1:    r = 34'd6871947673;
         3'd2:    r = 34'd687194767;
         3'd3:    r = 34'd68719476;
         3'd4:    r = 34'd6871947;
         3'd5:    r = 34'd687194;
         3'd6:    r = 34'd68719;
         default: r = 34'd0;
      endcase
      return r;
   endfunction

endpackage

### rtl/potok_ram.sv
// ---------------------------------------------------------------------------
// potok_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module potok_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/potok_front.sv
// ---------------------------------------------------------------------------
// potok_front
// Byte tokenizer: lookahead, number accumulation, operator recognition.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module potok_front #(
   parameter int STACK_DEPTH     = potok_pkg::STACK_DEPTH_DEF,
   parameter int FRACTION_DIGITS = potok_pkg::FRACTION_DIGITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [7:0]       in_byte,
   input  logic             in_last,
   output logic             op_valid,
   output potok_pkg::op_type op,
   input  logic             op_ready
);
   import potok_pkg::*;

   localparam int CW = $clog2(STACK_DEPTH + 1);

   typedef struct packed {
      logic        active;
      logic        stopped;
      logic        point;
      logic [31:0] int_acc;
      logic [19:0] frac_acc;
      logic [2:0]  frac_cnt;
   } tok_type;

   function automatic tok_type tok_byte(input tok_type t, input logic [7:0] c);
      tok_type     r;
      logic [35:0] wide;
      logic [3:0]  d;
      r    = t;
      d    = 4'(c - CHAR_ZERO);
      wide = {t.int_acc, 3'b000} + {3'b000, t.int_acc, 1'b0} + {32'd0, d};
      if (!t.stopped) begin
         if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            if (!t.point) begin
               r.int_acc = (wide[35:32] != 4'd0) ? 32'hFFFF_FFFF : wide[31:0];
            end else if (t.frac_cnt < 3'(FRACTION_DIGITS)) begin
               r.frac_acc = 20'({t.frac_acc, 3'b000} + {t.frac_acc, 1'b0} + {19'd0, d});
               r.frac_cnt = t.frac_cnt + 3'd1;
            end
         end else if (c == CHAR_POINT && !t.point) begin
            r.point = 1'b1;
         end else begin
            r.stopped = 1'b1;
         end
      end
      return r;
   endfunction

   logic [7:0]    pend_ff, pend_in;
   logic          pvalid_ff, pvalid_in;
   logic [7:0]    prev_ff, prev_in;
   tok_type       tok_ff, tok_in;
   logic [1:0]    skip_ff, skip_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   logic       accept;
   logic [7:0] cur;
   logic       next_lower;
   tok_type    fresh;

   assign in_ready   = op_ready;
   assign accept     = in_valid & op_ready;
   assign cur        = pend_ff;
   assign next_lower = (in_byte >= CHAR_LOW_A) && (in_byte <= CHAR_LOW_Z);

   always_comb begin
      pend_in   = pend_ff;
      pvalid_in = pvalid_ff;
      prev_in   = prev_ff;
      tok_in    = tok_ff;
      skip_in   = skip_ff;
      cnt_in    = cnt_ff;
      op_valid  = 1'b0;
      op        = '0;
      fresh     = '0;
      fresh.active = 1'b1;
      if (accept) begin
         if (pvalid_ff) begin
            prev_in = pend_ff;
            if (skip_ff != 2'd0) begin
               skip_in = skip_ff - 2'd1;
            end else if (tok_ff.active) begin
               if (cur == CHAR_SPACE) begin
                  op_valid    = 1'b1;
                  op.int_part = tok_ff.int_acc;
                  op.frac_acc = tok_ff.frac_acc;
                  op.frac_cnt = tok_ff.frac_cnt;
                  if (cnt_ff < CW'(STACK_DEPTH)) begin
                     cnt_in = cnt_ff + CW'(1);
                  end
                  tok_in = '0;
               end else begin
                  tok_in = tok_byte(tok_ff, cur);
               end
            end else if (cur >= CHAR_ZERO && cur <= CHAR_NINE) begin
               tok_in = tok_byte(fresh, cur);
            end else if (prev_ff == CHAR_SPACE) begin
               op.is_cmd = 1'b1;
               if (cur == CHAR_C && in_byte == CHAR_M) begin
                  op_valid     = 1'b1;
                  op.kind      = CMD_MATRIX;
                  op.underflow = cnt_ff < CW'(6);
                  op.pop_n     = op.underflow ? 3'(cnt_ff) : 3'd6;
                  cnt_in       = cnt_ff - CW'(op.pop_n);
                  skip_in      = 2'd2;
               end else if (cur == CHAR_M && !next_lower) begin
                  op_valid     = 1'b1;
                  op.kind      = CMD_MOVETO;
                  op.underflow = cnt_ff < CW'(2);
                  op.pop_n     = op.underflow ? 3'(cnt_ff) : 3'd2;
                  cnt_in       = cnt_ff - CW'(op.pop_n);
               end else if (cur == CHAR_C && !next_lower && cnt_ff >= CW'(6)) begin
                  op_valid = 1'b1;
                  op.kind  = CMD_CURVETO;
                  op.pop_n = 3'd6;
                  cnt_in   = cnt_ff - CW'(6);
               end else if (cur == CHAR_L && !next_lower && cnt_ff >= CW'(2)) begin
                  op_valid = 1'b1;
                  op.kind  = CMD_LINETO;
                  op.pop_n = 3'd2;
                  cnt_in   = cnt_ff - CW'(2);
               end else if (cur == CHAR_Q) begin
                  op_valid = 1'b1;
                  op.kind  = CMD_SAVE;
               end
            end
         end
         if (in_last) begin
            pend_in   = '0;
            pvalid_in = 1'b0;
            prev_in   = '0;
            tok_in    = '0;
            skip_in   = '0;
            cnt_in    = '0;
         end else begin
            pend_in   = in_byte;
            pvalid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff   <= '0;
         pvalid_ff <= 1'b0;
         prev_ff   <= '0;
         tok_ff    <= '0;
         skip_ff   <= '0;
         cnt_ff    <= '0;
      end else begin
         pend_ff   <= pend_in;
         pvalid_ff <= pvalid_in;
         prev_ff   <= prev_in;
         tok_ff    <= tok_in;
         skip_ff   <= skip_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

### rtl/potok_queue.sv
// ---------------------------------------------------------------------------
// potok_queue
// Short FIFO between the tokenizer and the stack engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module potok_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   input  potok_pkg::op_type wr_op,
   output logic              wr_ready,
   output logic              rd_valid,
   output potok_pkg::op_type rd_op,
   input  logic              rd_ready
);
   import potok_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   op_type        buf_ff [DEPTH];
   logic [AW-1:0] wptr_ff, wptr_in;
   logic [AW-1:0] rptr_ff, rptr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          push, pop;

   assign wr_ready = cnt_ff != CW'(DEPTH);
   assign rd_valid = cnt_ff != CW'(0);
   assign rd_op    = buf_ff[rptr_ff];
   assign push     = wr_valid & wr_ready;
   assign pop      = rd_valid & rd_ready;

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (push) begin
         wptr_in = (wptr_ff == AW'(DEPTH - 1)) ? '0 : wptr_ff + AW'(1);
      end
      if (pop) begin
         rptr_in = (rptr_ff == AW'(DEPTH - 1)) ? '0 : rptr_ff + AW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wptr_ff] <= wr_op;
      end
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

### rtl/potok_back.sv
// ---------------------------------------------------------------------------
// potok_back
// Stack engine: Q32.16 conversion, ring-buffer operand stack, command output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module potok_back #(
   parameter int STACK_DEPTH = potok_pkg::STACK_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              op_valid,
   input  potok_pkg::op_type op,
   output logic              op_ready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [287:0]      rsp_tdata,
   output logic [3:0]        rsp_tuser
);
   import potok_pkg::*;

   localparam int TW = $clog2(STACK_DEPTH);

   // conversion pipe: stage 1 estimate, stage 2 correction
   logic          s1_valid_ff, s1_valid_in;
   op_type        s1_op_ff;
   logic [16:0]   s1_q0_ff;
   logic          s2_valid_ff, s2_valid_in;
   op_type        s2_op_ff;
   logic [47:0]   s2_value_ff;

   logic          adv, exec_take;
   logic [53:0]   prod;
   logic [36:0]   rem;
   logic [16:0]   q_fix;
   logic [15:0]   frac16;

   assign adv      = !s2_valid_ff || exec_take;
   assign op_ready = adv;
   assign prod     = {34'd0, op.frac_acc} * {20'd0, recip_ten(op.frac_cnt)};
   assign rem      = {1'b0, s1_op_ff.frac_acc, 16'd0}
                     - 37'({20'd0, s1_q0_ff} * {17'd0, pow_ten(s1_op_ff.frac_cnt)});
   assign q_fix    = (rem >= {17'd0, pow_ten(s1_op_ff.frac_cnt)}) ? s1_q0_ff + 17'd1
                                                                 : s1_q0_ff;
   assign frac16   = q_fix[16] ? 16'hFFFF : q_fix[15:0];

   assign s1_valid_in = adv ? op_valid : s1_valid_ff;
   assign s2_valid_in = adv ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_op_ff    <= op;
         s1_q0_ff    <= prod[36:20];
         s2_op_ff    <= s1_op_ff;
         s2_value_ff <= {s1_op_ff.int_part, frac16};
      end
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // execution
   exec_state_type state_ff, state_in;
   logic [TW-1:0]  top_ff, top_in;
   logic [2:0]     left_ff, left_in;
   logic [2:0]     cap_ff, cap_in;
   logic [2:0]     slot_ff, slot_in;
   logic           rdv_ff, rdv_in;
   logic [47:0]    vals_ff [NUM_VALUES];
   logic [47:0]    vals_in [NUM_VALUES];
   cmd_kind_type   kind_ff, kind_in;
   logic           under_ff, under_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [287:0]   rsp_data_ff, rsp_data_in;
   logic [3:0]     rsp_user_ff, rsp_user_in;

   logic           wr_en, rd_en;
   logic [TW-1:0]  top_dec;
   logic [47:0]    rd_data;

   assign top_dec = (top_ff == '0) ? TW'(STACK_DEPTH - 1) : top_ff - TW'(1);

   potok_ram #(.WIDTH(VALUE_W), .DEPTH(STACK_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (top_ff),
      .wr_data (s2_value_ff),
      .rd_en   (rd_en),
      .rd_addr (top_dec),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in    = state_ff;
      top_in      = top_ff;
      left_in     = left_ff;
      cap_in      = cap_ff;
      slot_in     = slot_ff;
      rdv_in      = 1'b0;
      vals_in     = vals_ff;
      kind_in     = kind_ff;
      under_in    = under_ff;
      exec_take   = 1'b0;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      case (state_ff)
         EX_IDLE: begin
            if (s2_valid_ff) begin
               exec_take = 1'b1;
               if (!s2_op_ff.is_cmd) begin
                  wr_en  = 1'b1;
                  top_in = (top_ff == TW'(STACK_DEPTH - 1)) ? '0 : top_ff + TW'(1);
               end else begin
                  for (int i = 0; i < NUM_VALUES; i++) begin
                     vals_in[i] = '0;
                  end
                  kind_in  = s2_op_ff.kind;
                  under_in = s2_op_ff.underflow;
                  left_in  = s2_op_ff.pop_n;
                  cap_in   = s2_op_ff.pop_n;
                  slot_in  = (s2_op_ff.kind inside {CMD_MATRIX, CMD_CURVETO}) ? 3'd5 : 3'd1;
                  state_in = (s2_op_ff.pop_n == 3'd0) ? EX_OUT : EX_POP;
               end
            end
         end
         EX_POP: begin
            if (left_ff != 3'd0) begin
               rd_en   = 1'b1;
               rdv_in  = 1'b1;
               top_in  = top_dec;
               left_in = left_ff - 3'd1;
            end
            if (rdv_ff) begin
               vals_in[slot_ff] = rd_data;
               slot_in = slot_ff - 3'd1;
               cap_in  = cap_ff - 3'd1;
               if (cap_ff == 3'd1) begin
                  state_in = EX_OUT;
               end
            end
         end
         EX_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {vals_ff[5], vals_ff[4], vals_ff[3],
                               vals_ff[2], vals_ff[1], vals_ff[0]};
               rsp_user_in  = {under_ff, kind_ff};
               state_in     = EX_IDLE;
            end
         end
         default: begin
            state_in = EX_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      left_ff     <= left_in;
      cap_ff      <= cap_in;
      slot_ff     <= slot_in;
      vals_ff     <= vals_in;
      kind_ff     <= kind_in;
      under_ff    <= under_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      if (reset) begin
         state_ff     <= EX_IDLE;
         top_ff       <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

### rtl/path_operator_tokenizer_unit.sv
// ---------------------------------------------------------------------------
// path_operator_tokenizer_unit
// Tokenizes a content byte stream and emits path/matrix commands.
// ---------------------------------------------------------------------------
//  channel | dir | payload
//  req_    | in  | tdata[7:0] stream byte, tlast end of stream
//  rsp_    | out | tdata value_a..value_f (48b each), tuser kind + underflow
//
//  One byte per cycle is taken while the queue has room. The stack engine
//  writes a push to the stack RAM; a command pops its operands one at a time
//  (one RAM read port, up to 6 for cm and c), then emits its result. A command
//  is recognised when its lookahead byte is taken, then passes the queue, the
//  conversion stages and the stack engine. Reset is synchronous; the stack
//  RAM needs no clearing. Output stalls back up through the queue to req_tready.
`timescale 1ns / 1ps

module path_operator_tokenizer_unit #(
   parameter int STACK_DEPTH     = potok_pkg::STACK_DEPTH_DEF,
   parameter int FRACTION_DIGITS = potok_pkg::FRACTION_DIGITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] stream_byte
   input  logic         req_tlast,   // stream_end
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [287:0] rsp_tdata,   // value_a, value_b, ..., value_f (48b each)
   output logic [3:0]   rsp_tuser    // [2:0] command_kind, [3] underflow_flag
);
   import potok_pkg::*;

   logic   f_valid, f_ready;
   op_type f_op;
   logic   q_valid, q_ready;
   op_type q_op;

   potok_front #(.STACK_DEPTH(STACK_DEPTH), .FRACTION_DIGITS(FRACTION_DIGITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_byte  (req_tdata),
      .in_last  (req_tlast),
      .op_valid (f_valid),
      .op       (f_op),
      .op_ready (f_ready)
   );

   potok_queue #(.DEPTH(4)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (f_valid),
      .wr_op    (f_op),
      .wr_ready (f_ready),
      .rd_valid (q_valid),
      .rd_op    (q_op),
      .rd_ready (q_ready)
   );

   potok_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .op_valid   (q_valid),
      .op         (q_op),
      .op_ready   (q_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### rtl/potok_checker.sv
// ---------------------------------------------------------------------------
// potok_checker
// Port-level checks of the tokenizer result channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "path_operator_tokenizer_unit_defines.svh"

module potok_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [287:0] rsp_tdata,
   input logic [3:0]   rsp_tuser
);
   import potok_pkg::*;

   `POTOK_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp dropped")
   `POTOK_ASSERT_NOW(a_under_kind, clock, reset, rsp_tvalid && rsp_tuser[3], rsp_tuser[2:0] == CMD_MATRIX || rsp_tuser[2:0] == CMD_MOVETO, "underflow on wrong kind")
   `POTOK_ASSERT_NOW(a_save_zero, clock, reset, rsp_tvalid && rsp_tuser[2:0] == CMD_SAVE, rsp_tdata == '0, "save carries values")
   `POTOK_ASSERT_NOW(a_two_op_zero, clock, reset, rsp_tvalid && (rsp_tuser[2:0] == CMD_MOVETO || rsp_tuser[2:0] == CMD_LINETO), rsp_tdata[287:96] == '0, "unused values set")

endmodule

bind path_operator_tokenizer_unit potok_checker u_potok_checker (.*);

### verif/path_operator_tokenizer_unit_test.sv
// ---------------------------------------------------------------------------
// path_operator_tokenizer_unit_test
// Drives content byte streams into the tokenizer, predicts the commands it
// emits (operand stack, number conversion, operator context rules) and
// compares every result transaction field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module path_operator_tokenizer_unit_test;
   import potok_pkg::*;

   localparam int DEPTH = STACK_DEPTH_DEF;
   localparam int FDIG = FRACTION_DIGITS_DEF;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      cmd_kind_type kind;
      logic [47:0]  val [6];
      logic         underflow;
   } command_type;

   typedef struct {
      logic [7:0] data;
      logic       last;
      logic       has_exp;
      logic [2:0] exp_kind;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [287:0] rsp_tdata;
   logic [3:0] rsp_tuser;

   path_operator_tokenizer_unit dut (.*);

   always #5 clock = ~clock;

   // predictor state
   logic [47:0] opstack [DEPTH];
   int          sp;
   logic [7:0]  pend_byte, prev_byte;
   logic        pend_ok, tok_on, tok_stop, got_point;
   logic [31:0] int_acc;
   logic [19:0] frac_acc;
   int          frac_cnt, skip_n;

   command_type cmd_queue [$];
   int  errors = 0;
   int  idle_cycles = 0;
   int  send_pct = 0, recv_pct = 0;
   bit  hold_rx = 0;
   bit  done = 0;

   function automatic void clear_number();
      tok_on = 0; tok_stop = 0; got_point = 0;
      int_acc = '0; frac_acc = '0; frac_cnt = 0;
   endfunction

   function automatic void clear_all();
      sp = 0; pend_byte = '0; pend_ok = 0; prev_byte = '0; skip_n = 0;
      clear_number();
   endfunction

   function automatic void push_value(logic [47:0] v);
      if (sp >= DEPTH) begin
         for (int i = 0; i < DEPTH - 1; i++) opstack[i] = opstack[i + 1];
         opstack[DEPTH - 1] = v;
      end else begin
         opstack[sp] = v;
         sp++;
      end
   endfunction

   function automatic logic [47:0] pop_value(ref bit miss);
      if (sp == 0) begin
         miss = 1;
         return '0;
      end
      sp--;
      return opstack[sp];
   endfunction

   function automatic void number_byte(logic [7:0] c);
      logic [35:0] wide;
      if (tok_stop) return;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         if (!got_point) begin
            wide = int_acc * 36'd10 + (c - CHAR_ZERO);
            int_acc = (wide > 36'hFFFFFFFF) ? 32'hFFFFFFFF : wide[31:0];
         end else if (frac_cnt < FDIG) begin
            frac_acc = 20'(frac_acc * 20'd10 + 20'(c - CHAR_ZERO));
            frac_cnt++;
         end
      end else if (c == CHAR_POINT && !got_point) begin
         got_point = 1;
      end else begin
         tok_stop = 1;
      end
   endfunction

   function automatic logic [47:0] number_value();
      longint unsigned p, f;
      p = 1;
      for (int i = 0; i < frac_cnt; i++) p *= 10;
      f = (longint'(frac_acc) << 16) / p;
      if (f > 16'hFFFF) f = 16'hFFFF;
      return {int_acc, f[15:0]};
   endfunction

   function automatic bit is_lower(logic [7:0] c);
      return c >= CHAR_LOW_A && c <= CHAR_LOW_Z;
   endfunction

   function automatic bit examine_byte(logic [7:0] cur, logic [7:0] nxt,
                                       output command_type cmd);
      bit miss;
      miss = 0;
      cmd.kind = CMD_SAVE;
      cmd.underflow = 0;
      for (int i = 0; i < 6; i++) cmd.val[i] = '0;
      if (skip_n > 0) begin
         skip_n--;
         return 0;
      end
      if (tok_on) begin
         if (cur == CHAR_SPACE) begin
            push_value(number_value());
            clear_number();
         end else begin
            number_byte(cur);
         end
         return 0;
      end
      if (cur >= CHAR_ZERO && cur <= CHAR_NINE) begin
         clear_number();
         tok_on = 1;
         number_byte(cur);
         return 0;
      end
      if (prev_byte != CHAR_SPACE) return 0;
      if (cur == CHAR_C && nxt == CHAR_M) begin
         for (int i = 5; i >= 0; i--) cmd.val[i] = pop_value(miss);
         cmd.kind = CMD_MATRIX;
         cmd.underflow = miss;
         skip_n = 2;
         return 1;
      end
      if (cur == CHAR_M && !is_lower(nxt)) begin
         cmd.val[1] = pop_value(miss);
         cmd.val[0] = pop_value(miss);
         cmd.kind = CMD_MOVETO;
         cmd.underflow = miss;
         return 1;
      end
      if (cur == CHAR_C && !is_lower(nxt) && sp >= 6) begin
         for (int i = 5; i >= 0; i--) cmd.val[i] = pop_value(miss);
         cmd.kind = CMD_CURVETO;
         return 1;
      end
      if (cur == CHAR_L && !is_lower(nxt) && sp >= 2) begin
         cmd.val[1] = pop_value(miss);
         cmd.val[0] = pop_value(miss);
         cmd.kind = CMD_LINETO;
         return 1;
      end
      if (cur == CHAR_Q) begin
         cmd.kind = CMD_SAVE;
         return 1;
      end
      return 0;
   endfunction

   // advance the predictor by one accepted byte; returns 1 if a command results
   function automatic bit predict_byte(logic [7:0] b, logic last, output command_type cmd);
      bit hit;
      hit = 0;
      if (pend_ok) begin
         hit = examine_byte(pend_byte, b, cmd);
         prev_byte = pend_byte;
      end
      if (hit) cmd_queue = {cmd_queue, cmd};
      if (last) begin
         clear_all();
      end else begin
         pend_byte = b;
         pend_ok = 1;
      end
      return hit;
   endfunction

   // valid stays up after a transaction; drain() drops it
   task automatic send_byte(logic [7:0] b, logic last);
      while (send_pct > 0 && $urandom_range(99) < send_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_checked(logic [7:0] b, logic last);
      command_type c;
      void'(predict_byte(b, last, c));
      send_byte(b, last);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (cmd_queue.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_checked(s[i], 1'b0);
   endtask

   function automatic string random_number();
      string s;
      int n;
      s = "";
      n = $urandom_range(1, ($urandom_range(9) == 0) ? 14 : 4);
      for (int i = 0; i < n; i++) s = {s, string'(8'(CHAR_ZERO + $urandom_range(9)))};
      if ($urandom_range(1)) begin
         s = {s, "."};
         n = $urandom_range(0, 8);
         for (int i = 0; i < n; i++) s = {s, string'(8'(CHAR_ZERO + $urandom_range(9)))};
      end
      case ($urandom_range(15))
         0: s = {s, "-"};
         1: s = {s, ".5"};
         2: s = {s, "e3x"};
         default: ;
      endcase
      return {s, " "};
   endfunction

   task automatic random_token();
      string s;
      int k;
      k = $urandom_range(99);
      if (k < 45) s = random_number();
      else if (k < 55) s = "m ";
      else if (k < 62) s = "l\n";
      else if (k < 70) s = "c ";
      else if (k < 76) s = "cm ";
      else if (k < 80) s = "q ";
      else if (k < 84) s = "Q ";
      else if (k < 87) s = "re ";
      else if (k < 89) s = "mq";
      else s = {string'(8'($urandom_range(255))), " "};
      send_text(s);
   endtask

   // receiver
   always @(negedge clock) begin
      if (reset || hold_rx) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_pct);
   end

   // checker and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("path_operator_tokenizer_unit_test: FAIL");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (cmd_queue.size() == 0) begin
               $error("unexpected command transaction kind=%0d", rsp_tuser[2:0]);
               errors++;
            end else begin
               command_type e;
               e = cmd_queue.pop_front();
               if (rsp_tuser[2:0] !== e.kind) begin
                  $error("command_kind exp %0d got %0d", e.kind, rsp_tuser[2:0]);
                  errors++;
               end
               if (rsp_tuser[3] !== e.underflow) begin
                  $error("underflow_flag exp %0d got %0d", e.underflow, rsp_tuser[3]);
                  errors++;
               end
               for (int i = 0; i < 6; i++)
                  if (rsp_tdata[48*i +: 48] !== e.val[i]) begin
                     $error("value_%s exp %h got %h", string'(8'("a" + i)), e.val[i],
                            rsp_tdata[48*i +: 48]);
                     errors++;
                  end
            end
         end
      end
   end

   // directed table: bytes from the stream start; expectation only where obvious
   dir_row_type dir_rows [$];

   task automatic add_row(string s, bit has, logic [2:0] k);
      dir_row_type r;
      for (int i = 0; i < s.len(); i++) begin
         r = '{s[i], 1'b0, (i == s.len() - 1) ? has : 1'b0, k};
         dir_rows = {dir_rows, r};
      end
   endtask

   initial begin : stimulus
      command_type c;
      bit hit;
      clear_all();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // q at stream start has no space before it: ignored
      add_row("q ", 0, 0);
      add_row(" m ", 1, CMD_MOVETO);       // underflow moveto, emitted on lookahead
      add_row("cm", 1, CMD_MATRIX);        // emitted when its m is the lookahead
      add_row(" ", 0, 0);
      add_row("q ", 1, CMD_SAVE);
      add_row("4294967296.999999 65535.00001 l ", 1, CMD_LINETO);
      add_row("0 1.5x 2..3 c ", 0, 0);      // too few operands: no curveto
      add_row("9 8 7 c\n", 1, CMD_CURVETO);
      add_row("ma ", 0, 0);
      foreach (dir_rows[i]) begin
         hit = predict_byte(dir_rows[i].data, dir_rows[i].last, c);
         if (dir_rows[i].has_exp && (!hit || c.kind != dir_rows[i].exp_kind)) begin
            $error("command_kind exp %0d got %0d", dir_rows[i].exp_kind, c.kind);
            errors++;
         end
         send_byte(dir_rows[i].data, dir_rows[i].last);
      end
      send_checked(8'hFF, 1'b1);
      drain();

      // overflow the stack, then hold the receiver while offering bytes
      send_text(" ");
      for (int i = 0; i < DEPTH + 4; i++) send_text($sformatf("%0d ", i));
      for (int i = 0; i < 6; i++) send_text("c ");
      hold_rx = 1;
      fork
         begin repeat (400) @(negedge clock); hold_rx = 0; end
         for (int i = 0; i < 30; i++) send_text("q ");
      join
      send_checked(8'h00, 1'b1);
      drain();

      for (int ph = 0; ph < 3; ph++) begin
         send_pct = (ph == 0) ? 9 : (ph == 1) ? 86 : 0;
         recv_pct = (ph == 0) ? 86 : (ph == 1) ? 9 : 0;
         for (int t = 0; t < 90; t++) begin
            random_token();
            if ($urandom_range(40) == 0) send_checked(8'($urandom_range(255)), 1'b1);
         end
         send_checked(8'h20, 1'b1);
         drain();
      end

      done = 1;
      if (errors == 0 && cmd_queue.size() == 0)
         $display("path_operator_tokenizer_unit_test: PASS");
      else
         $display("path_operator_tokenizer_unit_test: FAIL");
      $finish;
   end

endmodule
